// ----- hw/rtl/iida_pkg.sv -----
// Shared types and codes for the indexed insert/delete array.
// Used by iida_seq and indexed_insert_delete_array; no dependencies.
`default_nettype none

package iida_pkg;

    // Default number of storage entries
    localparam int MAX_ENTRIES_DEF = 16;

    // Field widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int CAP_W   = 5;
    localparam int FILL_W  = 5;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request modes
    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Finished result handed from the sequencer to the output register
    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  read_value;
        t_status                    status;
        logic [FILL_W-1:0]          fill_count;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/iida_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module iida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/iida_seq.sv -----
// Request sequencer: decodes a request, moves entries one at a time through
// the entry RAM and builds the result. Depends on iida_pkg and iida_ram.
`default_nettype none

module iida_seq #(
    parameter int MAX_ENTRIES = iida_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_req_valid,
    output logic                                      o_req_stall,
    input  wire logic [1:0]                           i_mode,
    input  wire logic signed [iida_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [iida_pkg::VALUE_W-1:0]  i_new_value,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]     i_cap_eff,
    input  wire logic                                 i_out_free,
    output iida_pkg::t_result                         o_result
);

    import iida_pkg::*;

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = CW + POS_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RD_WAIT = 6'b000010,
        S_SH_RD   = 6'b000100,
        S_SH_WR   = 6'b001000,
        S_INS_WR  = 6'b010000,
        S_RESP    = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0]                 r_mode, n_mode;
    logic signed [VALUE_W-1:0]  r_val, n_val;
    logic signed [VALUE_W-1:0]  r_rd_value, n_rd_value;
    t_status                    r_status, n_status;
    logic [CW-1:0]              r_used, n_used;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_at, n_at;

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [VALUE_W-1:0]         ram_wdata, ram_rdata;

    logic                       pos_neg;
    logic [CMPW-1:0]            pos_ext, used_ext;
    logic                       in_range, full;
    logic [CW-1:0]              ins_at;
    logic [CW-1:0]              idx_step;

    iida_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Decode position against the fill count
    always_comb begin
        pos_neg  = i_position[POS_W-1];
        pos_ext  = CMPW'(i_position[POS_W-2:0]);
        used_ext = CMPW'(r_used);
        in_range = !pos_neg && (pos_ext < used_ext);
        full     = (r_used >= i_cap_eff);
        if (pos_neg) begin
            ins_at = '0;
        end else if (pos_ext > used_ext) begin
            ins_at = r_used;
        end else begin
            ins_at = CW'(i_position[POS_W-2:0]);
        end
    end

    // Shared index unit: step down for insert, up for delete
    assign idx_step = (r_mode == MODE_INSERT) ? (r_idx - 1'b1) : (r_idx + 1'b1);

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_val      = r_val;
        n_rd_value = r_rd_value;
        n_status   = r_status;
        n_used     = r_used;
        n_idx      = r_idx;
        n_at       = r_at;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = '0;
        ram_raddr  = '0;
        ram_wdata  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_mode     = i_mode;
                    n_val      = i_new_value;
                    n_rd_value = '0;
                    n_status   = ST_OK;
                    n_state    = S_RESP;
                    unique case (i_mode)
                        MODE_READ: begin
                            if (in_range) begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(i_position[POS_W-2:0]);
                                n_state   = S_RD_WAIT;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        MODE_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_at    = ins_at;
                                n_idx   = r_used;
                                n_used  = r_used + 1'b1;
                                n_state = (r_used > ins_at) ? S_SH_RD : S_INS_WR;
                            end
                        end
                        MODE_DELETE: begin
                            if (in_range) begin
                                n_idx  = CW'(i_position[POS_W-2:0]);
                                n_used = r_used - 1'b1;
                                if ((pos_ext + 1'b1) < used_ext) begin
                                    n_state = S_SH_RD;
                                end
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_rd_value = ram_rdata;
                n_state    = S_RESP;
            end
            S_SH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(idx_step);
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_idx);
                ram_wdata = ram_rdata;
                n_idx     = idx_step;
                if (r_mode == MODE_INSERT) begin
                    n_state = (idx_step > r_at) ? S_SH_RD : S_INS_WR;
                end else begin
                    n_state = (idx_step < r_used) ? S_SH_RD : S_RESP;
                end
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_at);
                ram_wdata = r_val;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_val      <= n_val;
        r_rd_value <= n_rd_value;
        r_status   <= n_status;
        r_idx      <= n_idx;
        r_at       <= n_at;
    end

    // Present handshake and result
    assign o_req_stall = (r_state != S_IDLE);

    always_comb begin
        o_result.valid      = (r_state == S_RESP);
        o_result.read_value = r_rd_value;
        o_result.status     = r_status;
        o_result.fill_count = FILL_W'(r_used);
    end

    // Fill count never passes the storage depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_ENTRIES))
        else $error("fill count above storage depth");

    // An accepted insert with room grows the fill by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid && i_mode == MODE_INSERT && !full)
        |=> (r_used == $past(r_used) + 1'b1))
        else $error("insert did not grow fill count");

    // RAM writes happen only while moving entries or placing a new value
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SH_WR || r_state == S_INS_WR))
        else $error("RAM write outside shift or insert");

    // A refused insert leaves the fill count unchanged
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid && i_mode == MODE_INSERT && full)
        |=> (r_used == $past(r_used)))
        else $error("refused insert changed fill count");

endmodule

`default_nettype wire

// ----- hw/rtl/indexed_insert_delete_array.sv -----
// Top level: capacity register, output result register and the sequencer.
// Depends on iida_pkg, iida_seq and iida_ram.
`default_nettype none

// Ordered array of signed 32-bit words addressed by position. Each request
// reads, inserts or deletes one entry and returns one result with a status
// and the fill count after the request. Entries live in a single-port-write,
// registered-read RAM and are moved one at a time by a small sequencer that
// reads each moved entry and then writes it to its new place. The block
// takes one request at a time; a finished result sits in an output register
// so the sequencer can start the next request while it waits. Capacity must
// be written only while the block is idle; the block itself does not enforce
// it. A value of zero acts as one and a value above the storage depth acts
// as the depth. There is no clearing pass after reset.
module indexed_insert_delete_array #(
    parameter int MAX_ENTRIES = iida_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [1:0]                           i_mode,
    input  wire logic signed [iida_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [iida_pkg::VALUE_W-1:0]  i_new_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [iida_pkg::VALUE_W-1:0]       o_read_value,
    output logic [1:0]                                o_status,
    output logic [iida_pkg::FILL_W-1:0]               o_fill_count,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [iida_pkg::CAP_W-1:0]           i_cfg_wr_data
);

    import iida_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [CAP_W-1:0]          r_cap;
    logic [CW-1:0]             cap_eff;
    t_result                   seq_result;
    logic                      out_free;
    logic                      r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    t_status                   r_out_status;
    logic [FILL_W-1:0]         r_out_fill;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // Saturate capacity to one..depth
    always_comb begin
        priority if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else if (int'(r_cap) > MAX_ENTRIES) begin
            cap_eff = CW'(MAX_ENTRIES);
        end else begin
            cap_eff = CW'(r_cap);
        end
    end

    iida_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_stall (o_in_stall),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_new_value (i_new_value),
        .i_cap_eff   (cap_eff),
        .i_out_free  (out_free),
        .o_result    (seq_result)
    );

    // Output register: load when empty or being taken
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (seq_result.valid && out_free) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_result.valid && out_free) begin
            r_out_value  <= seq_result.read_value;
            r_out_status <= seq_result.status;
            r_out_fill   <= seq_result.fill_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_fill_count = r_out_fill;

endmodule

`default_nettype wire

// ----- dv/tb_indexed_insert_delete_array.sv -----
// Self-checking testbench for indexed_insert_delete_array: drives read, insert and delete
// requests under random idling, predicts every result in SystemVerilog and compares them.
// Depends on iida_pkg and the indexed_insert_delete_array RTL.
`default_nettype none

module tb_indexed_insert_delete_array;
    timeunit 1ns;
    timeprecision 1ps;

    import iida_pkg::*;

    localparam int          DEPTH       = MAX_ENTRIES_DEF;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          LONG_HOLD   = 300;
    localparam int          SETTLE      = 40;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [POS_W-1:0]    position;
        logic signed [VALUE_W-1:0]  new_value;
    } t_request;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        t_status                    status;
        logic [FILL_W-1:0]          fill_count;
    } t_array_result;

    // DUT connections
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [1:0]                 i_mode;
    logic signed [POS_W-1:0]    i_position;
    logic signed [VALUE_W-1:0]  i_new_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [VALUE_W-1:0]  o_read_value;
    logic [1:0]                 o_status;
    logic [FILL_W-1:0]          o_fill_count;
    logic                       i_cfg_wr_en;
    logic [CAP_W-1:0]           i_cfg_wr_data;

    // Array shadow state
    logic signed [VALUE_W-1:0]  shadow_entries [DEPTH];
    int                         shadow_fill;
    logic [CAP_W-1:0]           shadow_capacity;

    // Stimulus and checking bookkeeping
    t_request                   request_queue [$];
    t_array_result              awaited_results [$];
    int                         requests_queued;
    int                         requests_taken;
    int                         results_checked;
    int                         full_refusals;
    int                         range_refusals;
    int                         error_count;
    logic                       req_taken;
    int                         send_gap;
    int                         stall_left;
    int                         hold_left;
    int                         hold_ticket;
    int                         hold_seen;
    bit                         quiet;

    indexed_insert_delete_array #(
        .MAX_ENTRIES (DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_fill_count  (o_fill_count),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Apply one request to the shadow array and return the result it should produce
    function automatic t_array_result apply_to_array(input t_request req);
        t_array_result res;
        int pos;
        int at;
        int cap;
        int i;
        pos = int'($signed(req.position));
        cap = int'(shadow_capacity);
        if (cap < 1) cap = 1;
        if (cap > DEPTH) cap = DEPTH;
        res.read_value = '0;
        res.status     = ST_OK;
        case (req.mode)
            MODE_READ: begin
                if (pos >= 0 && pos < shadow_fill) res.read_value = shadow_entries[pos];
                else res.status = ST_RANGE;
            end
            MODE_INSERT: begin
                if (shadow_fill >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    if (pos < 0) at = 0;
                    else if (pos > shadow_fill) at = shadow_fill;
                    else at = pos;
                    for (i = shadow_fill; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[at] = req.new_value;
                    shadow_fill++;
                end
            end
            MODE_DELETE: begin
                if (pos >= 0 && pos < shadow_fill) begin
                    for (i = pos; i + 1 < shadow_fill; i++) shadow_entries[i] = shadow_entries[i+1];
                    shadow_fill--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        res.fill_count = shadow_fill[FILL_W-1:0];
        return res;
    endfunction

    function automatic t_request make_request(input logic [1:0] mode, input int pos,
                                              input logic [VALUE_W-1:0] value);
        t_request req;
        req.mode      = mode;
        req.position  = pos[POS_W-1:0];
        req.new_value = value;
        return req;
    endfunction

    // Pick a request: mostly positions inside the array span, some anywhere in the byte
    function automatic t_request random_request(input int ins_pct, input int del_pct);
        t_request req;
        int roll;
        logic [31:0] bits;
        roll = $urandom_range(0, 99);
        if (roll < 3) req.mode = MODE_UNUSED;
        else if (roll < 3 + ins_pct) req.mode = MODE_INSERT;
        else if (roll < 3 + ins_pct + del_pct) req.mode = MODE_DELETE;
        else req.mode = MODE_READ;
        bits = $urandom();
        if ($urandom_range(0, 3) == 0) req.position = bits[POS_W-1:0];
        else req.position = POS_W'($urandom_range(0, DEPTH));
        case ($urandom_range(0, 15))
            0:       req.new_value = 32'h8000_0000;
            1:       req.new_value = 32'h7FFF_FFFF;
            2:       req.new_value = '0;
            default: req.new_value = $urandom();
        endcase
        return req;
    endfunction

    task automatic queue_request(input t_request req);
        request_queue.push_back(req);
        requests_queued++;
    endtask

    task automatic queue_random(input int count, input int ins_pct, input int del_pct);
        int n;
        for (n = 0; n < count; n++) queue_request(random_request(ins_pct, del_pct));
    endtask

    // Hold until every queued request has been taken and answered, then let the block settle
    task automatic wait_drained();
        while (request_queue.size() != 0 || requests_taken != requests_queued ||
               awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[CAP_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Check finished results and predict taken requests
    always @(posedge i_clk) begin : check_side
        t_array_result want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_wr_en) shadow_capacity = i_cfg_wr_data;
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: read_value %0d status %0d fill %0d",
                           o_read_value, o_status, o_fill_count);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d", want.read_value, o_read_value);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, actual %0d", want.fill_count,
                               o_fill_count);
                        error_count++;
                    end
                end
                results_checked++;
            end
            if (i_in_valid && !o_in_stall) begin
                want = apply_to_array(make_request(i_mode, int'(i_position), i_new_value));
                if (want.status == ST_FULL) full_refusals++;
                if (want.status == ST_RANGE) range_refusals++;
                awaited_results.push_back(want);
                requests_taken++;
            end
            req_taken <= i_in_valid && !o_in_stall;
        end
    end

    // Request driver: hold a stalled request, otherwise advance or idle for a burst
    always @(negedge i_clk) begin : request_driver
        t_request nxt;
        if (!i_in_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                nxt = request_queue.pop_front();
                i_mode      <= nxt.mode;
                i_position  <= nxt.position;
                i_new_value <= nxt.new_value;
                i_in_valid  <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result stall: long hold-off on request, otherwise random bursts
    always @(negedge i_clk) begin
        if (hold_seen != hold_ticket) begin
            hold_seen   <= hold_ticket;
            hold_left   <= LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus phases
    initial begin
        int ph;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_mode          = '0;
        i_position      = '0;
        i_new_value     = '0;
        i_out_stall     = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        shadow_fill     = 0;
        shadow_capacity = CAP_RESET;
        requests_queued = 0;
        requests_taken  = 0;
        results_checked = 0;
        full_refusals   = 0;
        range_refusals  = 0;
        error_count     = 0;
        req_taken       = 1'b0;
        send_gap        = 0;
        stall_left      = 0;
        hold_left       = 0;
        hold_ticket     = 0;
        hold_seen       = 0;
        quiet           = 1'b0;
        foreach (shadow_entries[k]) shadow_entries[k] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty array, unused mode, clamped inserts and the extremes of every field
        queue_request(make_request(MODE_READ,   0,    32'h0));
        queue_request(make_request(MODE_DELETE, 0,    32'h0));
        queue_request(make_request(MODE_UNUSED, 127,  32'hFFFF_FFFF));
        queue_request(make_request(MODE_INSERT, -128, 32'h8000_0000));
        queue_request(make_request(MODE_INSERT, 127,  32'h7FFF_FFFF));
        queue_request(make_request(MODE_INSERT, 1,    32'hFFFF_FFFF));
        queue_request(make_request(MODE_INSERT, 0,    32'h0));
        queue_request(make_request(MODE_INSERT, 4,    32'h5555_5555));
        queue_request(make_request(MODE_INSERT, 2,    32'hAAAA_AAAA));
        queue_request(make_request(MODE_READ,   0,    32'h0));
        queue_request(make_request(MODE_READ,   2,    32'h0));
        queue_request(make_request(MODE_READ,   5,    32'h0));
        queue_request(make_request(MODE_READ,   -1,   32'h0));
        queue_request(make_request(MODE_READ,   6,    32'h0));
        queue_request(make_request(MODE_READ,   127,  32'h0));
        queue_request(make_request(MODE_READ,   -128, 32'h0));
        queue_request(make_request(MODE_DELETE, 2,    32'h0));
        queue_request(make_request(MODE_DELETE, 4,    32'h0));
        queue_request(make_request(MODE_DELETE, 0,    32'h0));
        queue_request(make_request(MODE_DELETE, -1,   32'h0));
        queue_request(make_request(MODE_DELETE, 127,  32'h0));
        queue_request(make_request(MODE_READ,   0,    32'h0));
        queue_request(make_request(MODE_READ,   1,    32'h0));
        queue_request(make_request(MODE_UNUSED, -128, 32'h0));
        wait_drained();

        // Zero capacity acts as one, below the current fill
        write_capacity(0);
        queue_random(40, 40, 40);
        wait_drained();

        // Oversized capacity acts as the depth; hold off the receiver so the block backs up
        write_capacity(31);
        hold_ticket++;
        queue_random(300, 55, 20);
        wait_drained();

        write_capacity(1);
        queue_random(40, 30, 50);
        wait_drained();

        // Grow, shrink, then fill up before lowering the capacity under the fill
        write_capacity(16);
        queue_random(150, 60, 15);
        queue_random(150, 15, 60);
        queue_random(16, 97, 0);
        wait_drained();

        write_capacity(3);
        queue_random(60, 30, 20);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            write_capacity($urandom_range(0, 31));
            queue_random(150, 35, 30);
            wait_drained();
        end

        // Closing stretch with no idling on either side
        write_capacity(16);
        quiet = 1'b1;
        queue_random(200, 40, 35);
        wait_drained();

        $display("%0d requests taken, %0d results checked", requests_taken, results_checked);
        $display("%0d inserts refused as full, %0d reads/deletes out of range",
                 full_refusals, range_refusals);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
